FILE: design/ptq_pkg.sv
`timescale 1ns / 1ps
// Shared types, codes and helpers for the periodic timer queue.
// No dependencies; used by ptq_cell and periodic_timer_queue.
package ptq_pkg;

  // Default number of timer slots; slot numbers always fit in SLOT_W bits.
  localparam int N_TIMERS_DEF = 16;
  localparam int SLOT_W       = 8;

  // At most this many firings are reported for one tick.
  localparam int MAX_RESULTS = 16;
  localparam int FIRE_N_W    = $clog2(MAX_RESULTS + 1);

  // Command codes carried on the input channel.
  typedef enum logic [1:0] {
    CMD_TICK   = 2'd0,
    CMD_CREATE = 2'd1,
    CMD_CHANGE = 2'd2,
    CMD_DELETE = 2'd3
  } cmd_t;

  // Operations broadcast from the sequencer to the row of timer cells.
  typedef enum logic [2:0] {
    OP_NONE   = 3'd0,
    OP_CREATE = 3'd1,
    OP_CHANGE = 3'd2,
    OP_DELETE = 3'd3,
    OP_FIRE   = 3'd4
  } cell_op_t;

  // Broadcast control to every cell.
  typedef struct packed {
    cell_op_t          op;
    logic [SLOT_W-1:0] sel;
    logic [63:0]       expiry;
    logic [31:0]       interval;
  } cell_cmd_t;

  // Earliest-expiry candidate handed from cell to cell.
  typedef struct packed {
    logic              valid;
    logic [63:0]       expiry;
    logic [31:0]       fires;
    logic [SLOT_W-1:0] slot;
  } cand_t;

  // Adds a 32-bit value to a 64-bit time, saturating at all ones.
  function automatic logic [63:0] sat_add64(input logic [63:0] a, input logic [31:0] b);
    logic [64:0] sum;
    sum = {1'b0, a} + {33'b0, b};
    return sum[64] ? {64{1'b1}} : sum[63:0];
  endfunction

endpackage

FILE: design/ptq_cell.sv
`timescale 1ns / 1ps
// One timer slot of the queue plus its stage of the earliest-expiry chain.
// Depends on ptq_pkg.
module ptq_cell #(
  parameter int INDEX = 0
) (
  input  logic               clk,
  input  logic               rst_n,
  input  ptq_pkg::cell_cmd_t cmd,
  input  logic [63:0]        now_ms,
  input  ptq_pkg::cand_t     cand_in,
  output ptq_pkg::cand_t     cand_out
);
  import ptq_pkg::*;

  logic        armed_r;
  logic        expired_r;
  logic [63:0] expiry_r;
  logic [31:0] interval_r;
  logic [31:0] fires_r;
  cand_t       cand_r;
  cand_t       cand_nxt;
  logic        hit;
  logic        take_own;

  assign hit = (cmd.sel == SLOT_W'(INDEX));

  // Keep this slot only if it beats everything from lower slots; ties stay lower.
  assign take_own = expired_r && (!cand_in.valid || (expiry_r < cand_in.expiry));

  always_comb begin
    if (take_own) begin
      cand_nxt = '{valid: 1'b1, expiry: expiry_r, fires: fires_r, slot: SLOT_W'(INDEX)};
    end else begin
      cand_nxt = cand_in;
    end
  end

  // Control state: the active mark, the expired flag and the chain stage.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      armed_r   <= 1'b0;
      expired_r <= 1'b0;
      cand_r    <= '0;
    end else begin
      expired_r <= armed_r && (expiry_r <= now_ms);
      cand_r    <= cand_nxt;
      if (hit) begin
        unique case (cmd.op)
          OP_CREATE, OP_CHANGE: armed_r <= 1'b1;
          OP_DELETE:            armed_r <= 1'b0;
          OP_FIRE:              armed_r <= (interval_r != 32'd0);
          default:              armed_r <= armed_r;
        endcase
      end
    end
  end

  // Slot contents; undefined until written by a create (a change writes only the expiry and interval).
  always_ff @(posedge clk) begin
    if (hit) begin
      unique case (cmd.op)
        OP_CREATE: begin
          expiry_r   <= cmd.expiry;
          interval_r <= cmd.interval;
          fires_r    <= 32'd0;
        end
        OP_CHANGE: begin
          expiry_r   <= cmd.expiry;
          interval_r <= cmd.interval;
        end
        OP_FIRE: begin
          fires_r <= fires_r + 32'd1;
          if (interval_r != 32'd0) begin
            expiry_r <= sat_add64(expiry_r, interval_r);
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign cand_out = cand_r;

endmodule

FILE: design/periodic_timer_queue.sv
`timescale 1ns / 1ps
// Periodic timer queue: create, change and delete are applied without leaving idle.
// A tick fires at most sixteen timers; before each firing the sequencer sweeps the N_TIMERS
// registered cells and then decides the next firing, and a result stall holds the decision.
// One beat is accepted at a time; a result beat waits in an output register.
// Synchronous reset clears the clock, all active marks and the sequencer; slot contents
// stay undefined until written. Depends on ptq_pkg and ptq_cell.
module periodic_timer_queue #(
  parameter int N_TIMERS = ptq_pkg::N_TIMERS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_command,
  input  logic [3:0]  in_timer_index,
  input  logic [31:0] in_due_ms,
  input  logic [31:0] in_period_ms,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [3:0]  out_fired_index,
  output logic [31:0] out_fire_count,
  output logic        out_last
);
  import ptq_pkg::*;

  localparam int CNT_W = $clog2(N_TIMERS + 1);

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_SCAN   = 4'b0010,
    S_DECIDE = 4'b0100,
    S_FLUSH  = 4'b1000
  } state_t;

  state_t              state_r, state_nxt;
  logic [63:0]         now_r, now_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [FIRE_N_W-1:0] fire_n_r, fire_n_nxt;
  logic                pend_v_r, pend_v_nxt;
  logic [SLOT_W-1:0]   pend_slot_r, pend_slot_nxt;
  logic [31:0]         pend_cnt_r, pend_cnt_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [3:0]          out_idx_r, out_idx_nxt;
  logic [31:0]         out_cnt_r, out_cnt_nxt;
  logic                out_last_r, out_last_nxt;

  cell_cmd_t cell_cmd;
  cand_t     chain [N_TIMERS];
  cand_t     best;
  logic      in_beat;
  logic      out_free;
  logic      slot_ok;
  cmd_t      command;

  assign command  = cmd_t'(in_command);
  assign in_stall = (state_r != S_IDLE);
  assign in_beat  = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;
  assign slot_ok  = ({5'b0, in_timer_index} < 9'(N_TIMERS));
  assign best     = chain[N_TIMERS-1];

  // Row of timer cells; each hands its best candidate to the next.
  for (genvar k = 0; k < N_TIMERS; k++) begin : g_cell
    cand_t cin;
    if (k == 0) begin : g_first
      assign cin = '0;
    end else begin : g_next
      assign cin = chain[k-1];
    end
    ptq_cell #(.INDEX(k)) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .cmd      (cell_cmd),
      .now_ms   (now_r),
      .cand_in  (cin),
      .cand_out (chain[k])
    );
  end

  // Sequencer: commands, sweeps of the cell row, firings and result beats.
  always_comb begin
    state_nxt     = state_r;
    now_nxt       = now_r;
    cnt_nxt       = cnt_r;
    fire_n_nxt    = fire_n_r;
    pend_v_nxt    = pend_v_r;
    pend_slot_nxt = pend_slot_r;
    pend_cnt_nxt  = pend_cnt_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_idx_nxt   = out_idx_r;
    out_cnt_nxt   = out_cnt_r;
    out_last_nxt  = out_last_r;
    cell_cmd      = '{op: OP_NONE, sel: SLOT_W'({4'b0, in_timer_index}),
                      expiry: sat_add64(now_r, in_due_ms), interval: in_period_ms};

    unique case (state_r)
      S_IDLE: begin
        if (in_beat) begin
          if (command == CMD_TICK) begin
            now_nxt    = sat_add64(now_r, 32'd1);
            cnt_nxt    = '0;
            fire_n_nxt = '0;
            pend_v_nxt = 1'b0;
            state_nxt  = S_SCAN;
          end else if (slot_ok) begin
            unique case (command)
              CMD_CREATE: cell_cmd.op = OP_CREATE;
              CMD_CHANGE: cell_cmd.op = OP_CHANGE;
              default:    cell_cmd.op = OP_DELETE;
            endcase
          end
        end
      end
      S_SCAN: begin
        cnt_nxt = cnt_r + CNT_W'(1);
        if (cnt_r == CNT_W'(N_TIMERS)) begin
          state_nxt = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (out_free) begin
          if (best.valid) begin
            // Fire the winner; the previous firing is known not to be the last.
            cell_cmd.op  = OP_FIRE;
            cell_cmd.sel = best.slot;
            if (pend_v_r) begin
              out_valid_nxt = 1'b1;
              out_idx_nxt   = pend_slot_r[3:0];
              out_cnt_nxt   = pend_cnt_r;
              out_last_nxt  = 1'b0;
            end
            pend_v_nxt    = 1'b1;
            pend_slot_nxt = best.slot;
            pend_cnt_nxt  = best.fires + 32'd1;
            fire_n_nxt    = fire_n_r + FIRE_N_W'(1);
            cnt_nxt       = '0;
            if (fire_n_r == FIRE_N_W'(MAX_RESULTS - 1)) begin
              state_nxt = S_FLUSH;
            end else begin
              state_nxt = S_SCAN;
            end
          end else begin
            if (pend_v_r) begin
              out_valid_nxt = 1'b1;
              out_idx_nxt   = pend_slot_r[3:0];
              out_cnt_nxt   = pend_cnt_r;
              out_last_nxt  = 1'b1;
            end
            pend_v_nxt = 1'b0;
            state_nxt  = S_IDLE;
          end
        end
      end
      S_FLUSH: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_idx_nxt   = pend_slot_r[3:0];
          out_cnt_nxt   = pend_cnt_r;
          out_last_nxt  = 1'b1;
          pend_v_nxt    = 1'b0;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      now_r       <= '0;
      cnt_r       <= '0;
      fire_n_r    <= '0;
      pend_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      now_r       <= now_nxt;
      cnt_r       <= cnt_nxt;
      fire_n_r    <= fire_n_nxt;
      pend_v_r    <= pend_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    pend_slot_r <= pend_slot_nxt;
    pend_cnt_r  <= pend_cnt_nxt;
    out_idx_r   <= out_idx_nxt;
    out_cnt_r   <= out_cnt_nxt;
    out_last_r  <= out_last_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_fired_index = out_idx_r;
  assign out_fire_count  = out_cnt_r;
  assign out_last        = out_last_r;

  // No firing may be left pending once the sequencer is back at rest.
  a_idle_no_pending: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_IDLE |-> !pend_v_r)
    else $error("pending firing left behind in idle");

  // A tick beat always starts a sweep of the cell row.
  a_tick_scans: assert property (@(posedge clk) disable iff (!rst_n)
    in_beat && command == CMD_TICK |=> state_r == S_SCAN && cnt_r == '0)
    else $error("tick did not start a sweep");

  // After a firing the row is swept again or the last beat is flushed.
  a_fire_next: assert property (@(posedge clk) disable iff (!rst_n)
    cell_cmd.op == OP_FIRE |=> (state_r == S_SCAN || state_r == S_FLUSH) && pend_v_r)
    else $error("firing not followed by sweep or flush");

  // The per-tick firing count never passes the result limit.
  a_fire_limit: assert property (@(posedge clk) disable iff (!rst_n)
    fire_n_r <= FIRE_N_W'(MAX_RESULTS))
    else $error("too many firings in one tick");

endmodule
